>>> design/lpc_pkg.sv
// types, constants and the letter table of the letter-to-phone converter
`timescale 1ns / 1ps

package lpc_pkg;

    // phone codes, alphabetical by phone name
    localparam logic [4:0] PH_A   = 5'd0;
    localparam logic [4:0] PH_B   = 5'd1;
    localparam logic [4:0] PH_CH  = 5'd2;
    localparam logic [4:0] PH_D   = 5'd3;
    localparam logic [4:0] PH_DZ  = 5'd4;
    localparam logic [4:0] PH_DZH = 5'd5;
    localparam logic [4:0] PH_E   = 5'd6;
    localparam logic [4:0] PH_F   = 5'd7;
    localparam logic [4:0] PH_G   = 5'd8;
    localparam logic [4:0] PH_H   = 5'd9;
    localparam logic [4:0] PH_I   = 5'd10;
    localparam logic [4:0] PH_J   = 5'd11;
    localparam logic [4:0] PH_K   = 5'd12;
    localparam logic [4:0] PH_KH  = 5'd13;
    localparam logic [4:0] PH_L   = 5'd14;
    localparam logic [4:0] PH_M   = 5'd15;
    localparam logic [4:0] PH_N   = 5'd16;
    localparam logic [4:0] PH_O   = 5'd17;
    localparam logic [4:0] PH_P   = 5'd18;
    localparam logic [4:0] PH_R   = 5'd19;
    localparam logic [4:0] PH_S   = 5'd20;
    localparam logic [4:0] PH_SH  = 5'd21;
    localparam logic [4:0] PH_T   = 5'd22;
    localparam logic [4:0] PH_TS  = 5'd23;
    localparam logic [4:0] PH_U   = 5'd24;
    localparam logic [4:0] PH_V   = 5'd25;
    localparam logic [4:0] PH_Y   = 5'd26;
    localparam logic [4:0] PH_Z   = 5'd27;
    localparam logic [4:0] PH_ZH  = 5'd28;

    // windows-1251 bytes with special handling
    localparam logic [7:0] CH_D  = 8'hE4;
    localparam logic [7:0] CH_Z  = 8'hE7;
    localparam logic [7:0] CH_ZH = 8'hE6;

    localparam int MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        MAP_NONE,
        MAP_ONE,
        MAP_TWO,
        MAP_UNKNOWN
    } map_kind_t;

    typedef struct packed {
        map_kind_t  kind;
        logic [4:0] ph0;
        logic [4:0] ph1;
    } map_t;

    typedef struct packed {
        logic [4:0] phone_code;
        logic       phone_valid;
        logic       letter_error;
        logic       word_end;
        logic       run_last;
    } result_t;

    typedef struct packed {
        logic [1:0]                   count;
        result_t [MAX_RESULTS-1:0]    res;
    } bundle_t;

    typedef struct packed {
        logic held_d;
        logic dropping_word;
    } conv_state_t;

    function automatic map_t one_phone(input logic [4:0] ph);
        map_t m;
        m.kind = MAP_ONE;
        m.ph0  = ph;
        m.ph1  = PH_A;
        return m;
    endfunction

    function automatic map_t two_phones(input logic [4:0] a, input logic [4:0] b);
        map_t m;
        m.kind = MAP_TWO;
        m.ph0  = a;
        m.ph1  = b;
        return m;
    endfunction

    // letter table, d is handled outside
    function automatic map_t map_letter(input logic [7:0] c);
        map_t m;
        m.kind = MAP_UNKNOWN;
        m.ph0  = PH_A;
        m.ph1  = PH_A;
        unique case (c)
            8'hE0:   m = one_phone(PH_A);
            8'hE1:   m = one_phone(PH_B);
            8'hE2:   m = one_phone(PH_V);
            8'hE3:   m = one_phone(PH_H);
            8'hB4:   m = one_phone(PH_G);
            8'hE5:   m = one_phone(PH_E);
            8'hE6:   m = one_phone(PH_ZH);
            8'hE7:   m = one_phone(PH_Z);
            8'hE8:   m = one_phone(PH_Y);
            8'hB3:   m = one_phone(PH_I);
            8'hE9:   m = one_phone(PH_J);
            8'hEA:   m = one_phone(PH_K);
            8'hEB:   m = one_phone(PH_L);
            8'hEC:   m = one_phone(PH_M);
            8'hED:   m = one_phone(PH_N);
            8'hEE:   m = one_phone(PH_O);
            8'hEF:   m = one_phone(PH_P);
            8'hF0:   m = one_phone(PH_R);
            8'hF1:   m = one_phone(PH_S);
            8'hF2:   m = one_phone(PH_T);
            8'hF3:   m = one_phone(PH_U);
            8'hF4:   m = one_phone(PH_F);
            8'hF5:   m = one_phone(PH_KH);
            8'hF6:   m = one_phone(PH_TS);
            8'hF7:   m = one_phone(PH_CH);
            8'hF8:   m = one_phone(PH_SH);
            8'hBA:   m = two_phones(PH_J, PH_E);
            8'hBF:   m = two_phones(PH_J, PH_I);
            8'hF9:   m = two_phones(PH_SH, PH_CH);
            8'hFE:   m = two_phones(PH_J, PH_U);
            8'hFF:   m = two_phones(PH_J, PH_A);
            8'hFC, 8'h2D, 8'h27: m.kind = MAP_NONE;
            default: m.kind = MAP_UNKNOWN;
        endcase
        return m;
    endfunction

endpackage

>>> design/lpc_letter_if.sv
// handshake channel carrying one letter byte per transaction
`timescale 1ns / 1ps

interface lpc_letter_if;
    logic       valid;
    logic       ready;
    logic [7:0] letter_code;
    logic       last_letter;

    modport source (output valid, output letter_code, output last_letter, input ready);
    modport sink (input valid, input letter_code, input last_letter, output ready);
endinterface

>>> design/lpc_phone_if.sv
// handshake channel carrying one phone result per transaction
`timescale 1ns / 1ps

interface lpc_phone_if;
    logic       valid;
    logic       ready;
    logic [4:0] phone_code;
    logic       phone_valid;
    logic       letter_error;
    logic       word_end;
    logic       run_last;

    modport source (
        output valid, output phone_code, output phone_valid, output letter_error,
        output word_end, output run_last, input ready
    );
    modport sink (
        input valid, input phone_code, input phone_valid, input letter_error,
        input word_end, input run_last, output ready
    );
endinterface

>>> design/letter_to_phone_converter_core.sv
// top level of the ukrainian letter-to-phone converter
`timescale 1ns / 1ps
// a letter's first result is offered in the cycle after its transaction
// throughput: one letter per cycle while each letter gives at most one result and
//   phones are taken; the letter side waits while two or more results are held
// reset: rst_n clears the held d, the dropping flag and the result count at once

module letter_to_phone_converter_core (
    input  logic         clk,
    input  logic         rst_n,
    lpc_letter_if.sink   letters,
    lpc_phone_if.source  phones
);
    import lpc_pkg::*;

    // word state carried from letter to letter
    conv_state_t state_reg;
    conv_state_t state_next;
    bundle_t     bundle;
    result_t     out_res;
    logic        can_load;
    logic        accept;

    // letter transaction whenever the buffer can take the whole bundle
    assign letters.ready = can_load;
    assign accept        = letters.valid && can_load;

    // decode straight from the channel into the result register
    lpc_decoder u_decoder (
        .letter_code (letters.letter_code),
        .last_letter (letters.last_letter),
        .state_cur   (state_reg),
        .state_next  (state_next),
        .bundle      (bundle)
    );

    lpc_result_buffer u_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .bundle    (bundle),
        .out_ready (phones.ready),
        .can_load  (can_load),
        .out_valid (phones.valid),
        .out_res   (out_res)
    );

    assign phones.phone_code   = out_res.phone_code;
    assign phones.phone_valid  = out_res.phone_valid;
    assign phones.letter_error = out_res.letter_error;
    assign phones.word_end     = out_res.word_end;
    assign phones.run_last     = out_res.run_last;

    // state moves only on an accepted letter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/lpc_decoder.sv
// combinational decode of one letter into up to three phone results
`timescale 1ns / 1ps

module lpc_decoder (
    input  logic [7:0]          letter_code,
    input  logic                last_letter,
    input  lpc_pkg::conv_state_t state_cur,
    output lpc_pkg::conv_state_t state_next,
    output lpc_pkg::bundle_t    bundle
);
    import lpc_pkg::*;

    logic       ends;
    logic       done;
    logic [1:0] n;
    map_t       m;

    always_comb
    begin
        state_next = state_cur;
        bundle     = '0;
        n          = 2'd0;
        ends       = last_letter;
        done       = 1'b0;
        m          = map_letter(letter_code);

        if (state_cur.dropping_word)
        begin
            state_next.dropping_word = !last_letter;
        end
        else
        begin
            // pending d goes first, or merges into dz / dzh
            if (state_cur.held_d)
            begin
                state_next.held_d = 1'b0;
                if (letter_code == CH_Z || letter_code == CH_ZH)
                begin
                    bundle.res[n].phone_code  = (letter_code == CH_Z) ? PH_DZ : PH_DZH;
                    bundle.res[n].phone_valid = 1'b1;
                    n    = n + 2'd1;
                    done = 1'b1;
                end
                else
                begin
                    bundle.res[n].phone_code  = PH_D;
                    bundle.res[n].phone_valid = 1'b1;
                    n = n + 2'd1;
                end
            end

            if (!done && letter_code == CH_D)
            begin
                if (last_letter)
                begin
                    bundle.res[n].phone_code  = PH_D;
                    bundle.res[n].phone_valid = 1'b1;
                    n = n + 2'd1;
                end
                else
                begin
                    state_next.held_d = 1'b1;
                end
                done = 1'b1;
            end

            if (!done)
            begin
                unique case (m.kind)
                    MAP_UNKNOWN:
                    begin
                        bundle.res[n].letter_error = 1'b1;
                        n    = n + 2'd1;
                        ends = 1'b1;
                        state_next.dropping_word = !last_letter;
                    end
                    MAP_ONE:
                    begin
                        bundle.res[n].phone_code  = m.ph0;
                        bundle.res[n].phone_valid = 1'b1;
                        n = n + 2'd1;
                    end
                    MAP_TWO:
                    begin
                        bundle.res[n].phone_code  = m.ph0;
                        bundle.res[n].phone_valid = 1'b1;
                        n = n + 2'd1;
                        bundle.res[n].phone_code  = m.ph1;
                        bundle.res[n].phone_valid = 1'b1;
                        n = n + 2'd1;
                    end
                    MAP_NONE:
                    begin
                    end
                endcase
                // silent last letter still closes the word
                if (last_letter && n == 2'd0)
                begin
                    n = 2'd1;
                end
            end

            if (n != 2'd0)
            begin
                bundle.res[n - 2'd1].run_last = 1'b1;
                bundle.res[n - 2'd1].word_end = ends;
            end
        end
        bundle.count = n;
    end

endmodule

>>> design/lpc_result_buffer.sv
// three-entry result register drained one result per output transaction
`timescale 1ns / 1ps

module lpc_result_buffer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  lpc_pkg::bundle_t bundle,
    input  logic             out_ready,
    output logic             can_load,
    output logic             out_valid,
    output lpc_pkg::result_t out_res
);
    import lpc_pkg::*;

    logic [1:0]                count_reg;
    logic [1:0]                count_next;
    result_t [MAX_RESULTS-1:0] entry_reg;
    result_t [MAX_RESULTS-1:0] entry_next;
    logic                      pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_res   = entry_reg[0];
    assign pop       = out_valid && out_ready;
    // new bundle fits when empty or once the last held result leaves this cycle
    assign can_load  = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ready);

    always_comb
    begin
        count_next = count_reg;
        entry_next = entry_reg;
        if (load)
        begin
            count_next = bundle.count;
            entry_next = bundle.res;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                entry_next[i] = entry_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
